// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table bound search unit.
package stbs_pkg;

  // Fixed field widths of the ports.
  localparam int DATA_W  = 32;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;

  // Search index width: covers -1 up to the largest count plus one step of headroom.
  localparam int IDX_W = COUNT_W + 2;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // Index value reported when no entry qualifies.
  localparam logic signed [IDX_W-1:0] IDX_NONE = '1;

  // Operation codes of an input word.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Which of the three bounds the shared step unit is working on.
  typedef enum logic [1:0] {
    MODE_LOWER = 2'd0,
    MODE_UPPER = 2'd1,
    MODE_LAST  = 2'd2
  } search_mode_t;

  // Commands from the sequencer to the step unit.
  typedef struct packed {
    logic         load;
    logic         update;
    search_mode_t mode;
  } step_cmd_t;

endpackage

// ===== rtl/stbs_store.sv =====
// Element table memory with one write port and one registered read port.
module stbs_store import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/stbs_step.sv =====
// Shared bisection step unit: bounds registers, midpoint and the single compare.
module stbs_step import stbs_pkg::*; (
  input  logic                     clk,
  input  step_cmd_t                cmd,
  input  logic signed [IDX_W-1:0]  n,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] rd_data,
  output logic signed [IDX_W-1:0]  mid,
  output logic signed [IDX_W-1:0]  lo,
  output logic                     done
);

  logic signed [IDX_W-1:0] hi;
  logic signed [IDX_W-1:0] lo_next;
  logic signed [IDX_W-1:0] hi_next;
  logic signed [IDX_W-1:0] span;
  logic signed [IDX_W-1:0] half;
  logic [DATA_W:0]         diff;
  logic                    elem_lt;
  logic                    elem_gt;

  // Midpoint: the last-not-greater search rounds up, the other two round down.
  assign span = hi - lo;
  assign half = (cmd.mode == MODE_LAST) ? ((span + IDX_W'(1)) >>> 1) : (span >>> 1);
  assign mid  = lo + half;
  assign done = !(lo < hi);

  // One signed compare of the element against the key, by a 33-bit subtract.
  assign diff    = {rd_data[DATA_W-1], rd_data} - {key[DATA_W-1], key};
  assign elem_lt = diff[DATA_W];
  assign elem_gt = !elem_lt && (diff != '0);

  // Next bounds: start a search, or narrow the interval after one compare.
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (cmd.load) begin
      case (cmd.mode)
        MODE_LAST: begin
          lo_next = IDX_NONE;
          hi_next = n - IDX_W'(1);
        end
        default: begin
          lo_next = '0;
          hi_next = n;
        end
      endcase
    end else if (cmd.update) begin
      case (cmd.mode)
        MODE_LOWER: begin
          if (!elem_lt) hi_next = mid;
          else          lo_next = mid + IDX_W'(1);
        end
        MODE_UPPER: begin
          if (!elem_gt) lo_next = mid + IDX_W'(1);
          else          hi_next = mid;
        end
        MODE_LAST: begin
          if (!elem_gt) lo_next = mid;
          else          hi_next = mid - IDX_W'(1);
        end
        default: begin
          lo_next = lo;
          hi_next = hi;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
  end

endmodule

// ===== rtl/sorted_table_bound_search_unit.sv =====
// Sorted table bound search unit: input decode, search sequencer and result register.
//
// Usage: the input channel (in_valid/in_ready) carries one word per item. A word with
// op = 0 stores data_value into table position slot and gives no result; a slot at or
// beyond TABLE_DEPTH is ignored. A word with op = 1 is a query with data_value as key.
// Each query gives one result word on the output channel (out_valid/out_ready):
// lower_index (first entry >= key), upper_index (first entry > key), and
// last_not_greater_index (last entry <= key, or -1). The search covers the first
// element_count entries, saturated to TABLE_DEPTH; element_count is to be written
// through cfg_we/cfg_wdata only while the unit is idle; the unit does not enforce this.
// The table must be kept sorted ascending. A write leaves the unit idle. A query runs
// three binary searches one after the other through a single table read port and one
// shared compare; each step is a registered table read, then a compare. A search takes
// at most s = ceil(log2(n+1)) steps; the three bounds then go to the output register
// once it is free, and the unit returns to idle to take the next word.
// The unit takes no new word while a query runs, but it does take one while a
// finished result still waits in the output register. When the receiver stalls, a
// second finished query waits for that register to drain.
// Reset clears element_count and the control state; table contents stay undefined.
module sorted_table_bound_search_unit import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [COUNT_W-1:0]        cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [SLOT_W-1:0]         slot,
  input  logic signed [DATA_W-1:0]  data_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COUNT_W-1:0]        lower_index,
  output logic [COUNT_W-1:0]        upper_index,
  output logic signed [COUNT_W-1:0] last_not_greater_index
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_CMP   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                   state;
  state_t                   state_next;
  search_mode_t             mode;
  search_mode_t             mode_next;
  logic [COUNT_W-1:0]       element_count;
  logic signed [IDX_W-1:0]  n;
  logic signed [DATA_W-1:0] key;
  logic [COUNT_W-1:0]       lower_res;
  logic [COUNT_W-1:0]       upper_res;
  logic [COUNT_W-1:0]       last_res;
  step_cmd_t                cmd;
  logic signed [IDX_W-1:0]  mid;
  logic signed [IDX_W-1:0]  lo;
  logic                     done;
  logic signed [DATA_W-1:0] rd_data;
  logic [31:0]              mid_ext;
  logic [31:0]              slot_ext;
  logic                     in_fire;
  logic                     wr_en;
  logic                     out_load;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Table write decode; slots past the table end are dropped.
  assign slot_ext = 32'(slot);
  assign wr_en    = in_fire && (op == OP_WRITE) && (slot_ext < 32'(TABLE_DEPTH));
  assign mid_ext  = 32'(mid);

  stbs_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(slot_ext[AW-1:0]),
    .wr_data(data_value),
    .rd_addr(mid_ext[AW-1:0]),
    .rd_data(rd_data)
  );

  stbs_step u_step (
    .clk    (clk),
    .cmd    (cmd),
    .n      (n),
    .key    (key),
    .rd_data(rd_data),
    .mid    (mid),
    .lo     (lo),
    .done   (done)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (cfg_we) begin
      element_count <= cfg_wdata;
    end
  end

  // Query capture: key and the saturated entry count.
  always_ff @(posedge clk) begin
    if (in_fire && (op == OP_QUERY)) begin
      key <= data_value;
      if (32'(element_count) > 32'(TABLE_DEPTH)) n <= IDX_W'(TABLE_DEPTH);
      else                                        n <= IDX_W'(element_count);
    end
  end

  // Sequencer: three searches in turn, each alternating table read and compare.
  always_comb begin
    state_next = state;
    mode_next  = mode;
    cmd.load   = 1'b0;
    cmd.update = 1'b0;
    cmd.mode   = mode;
    case (state)
      S_IDLE: begin
        if (in_fire && (op == OP_QUERY)) begin
          state_next = S_LOAD;
          mode_next  = MODE_LOWER;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        if (done) begin
          case (mode)
            MODE_LOWER: begin
              mode_next  = MODE_UPPER;
              state_next = S_LOAD;
            end
            MODE_UPPER: begin
              mode_next  = MODE_LAST;
              state_next = S_LOAD;
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.update = 1'b1;
        state_next = S_ISSUE;
      end
      S_OUT: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_LOWER;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  // Capture each bound as its search finishes.
  always_ff @(posedge clk) begin
    if ((state == S_ISSUE) && done) begin
      case (mode)
        MODE_LOWER: lower_res <= lo[COUNT_W-1:0];
        MODE_UPPER: upper_res <= lo[COUNT_W-1:0];
        default:    last_res  <= lo[COUNT_W-1:0];
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      lower_index            <= lower_res;
      upper_index            <= upper_res;
      last_not_greater_index <= last_res;
    end
  end

`ifndef NO_ASSERTIONS
  // A new result word only appears after the sequencer reached its output state.
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result word appeared without a finished query");

  // An accepted query always starts a search on the next cycle.
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (op == OP_QUERY)) |=> (state == S_LOAD) && (mode == MODE_LOWER))
    else $error("query did not start the search sequence");

  // A table write leaves the unit ready.
  a_write_single: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (op == OP_WRITE)) |=> (state == S_IDLE))
    else $error("table write left the idle state");

  // While searching, the lower bound stays within -1 and the entry count.
  a_lo_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ISSUE) || (state == S_CMP)) |-> (lo >= IDX_NONE) && (lo <= n))
    else $error("search bound left the table range");

  // A compare step only ever follows a table read issue.
  a_cmp_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> $past(state == S_ISSUE))
    else $error("compare step without a preceding table read");
`endif

endmodule
